// ----- rtl/cdq_pkg.sv -----
// shared types and codes for the circular deque
package cdq_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned POP_W     = 32;
  localparam int unsigned PUSH_W    = 32;
  localparam int unsigned OUT_USER_W = STATUS_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic step;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;
  } dp_stat_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// controller state machine for the circular deque
module cdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  cdq_pkg::dp_stat_t  dp_stat,
  output logic               in_ready,
  output cdq_pkg::ctrl_cmd_t ctrl_cmd
);
  import cdq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!dp_stat.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl_cmd.step = 1'b0;
    ctrl_cmd.load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctrl_cmd.step = in_valid;
      end
      ST_RESP: begin
        ctrl_cmd.load = !dp_stat.out_stall;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/cdq_datapath.sv -----
// indices, entry memory and result register of the circular deque
module cdq_datapath #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cdq_pkg::ctrl_cmd_t                ctrl_cmd,
  output cdq_pkg::dp_stat_t                 dp_stat,
  input  logic [cdq_pkg::CMD_W-1:0]         in_cmd,
  input  logic [cdq_pkg::PUSH_W-1:0]        in_push,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cdq_pkg::POP_W-1:0]         out_pop,
  output logic [cdq_pkg::OUT_USER_W-1:0]    out_user
);
  import cdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = (DATA_WIDTH > POP_W) ? DATA_WIDTH : POP_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_up(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_down(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - AW'(1);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         front_r, front_nxt;
  logic [AW-1:0]         rear_r, rear_nxt;
  logic                  empty_r, empty_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  pop_ok_r, pop_ok_nxt;
  status_t               stat_r, stat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [POP_W-1:0]      out_pop_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic                  full_now;
  logic                  do_wr;
  logic                  do_rd;
  logic [AW-1:0]         slot;
  logic [EW-1:0]         push_ext;
  logic [EW-1:0]         pop_ext;
  cmd_t                  cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign full_now = !empty_r && (wrap_up(rear_r) == front_r);
  assign push_ext = EW'(in_push);
  assign pop_ext  = EW'($signed(rd_data_r));

  // state update for one step, taken at the transfer
  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    stat_nxt   = STAT_DONE;
    pop_ok_nxt = 1'b0;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    slot       = front_r;
    unique case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (full_now) begin
          stat_nxt = STAT_FULL;
        end else begin
          do_wr = 1'b1;
          if (empty_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b0;
            slot      = '0;
          end else if (cmd == CMD_PUSH_FRONT) begin
            front_nxt = wrap_down(front_r);
            slot      = wrap_down(front_r);
          end else begin
            rear_nxt = wrap_up(rear_r);
            slot     = wrap_up(rear_r);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (empty_r) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          do_rd      = 1'b1;
          pop_ok_nxt = 1'b1;
          slot       = (cmd == CMD_POP_FRONT) ? front_r : rear_r;
          if (front_r == rear_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (cmd == CMD_POP_FRONT) begin
            front_nxt = wrap_up(front_r);
          end else begin
            rear_nxt = wrap_down(rear_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.step && do_wr) begin
      mem[slot] <= push_ext[DATA_WIDTH-1:0];
    end
    if (ctrl_cmd.step && do_rd) begin
      rd_data_r <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
    end else if (ctrl_cmd.step) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.step) begin
      pop_ok_r <= pop_ok_nxt;
      stat_r   <= stat_nxt;
    end
  end

  // result register, loaded once the indices already show the state after the step
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl_cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      out_pop_r  <= pop_ok_r ? pop_ext[POP_W-1:0] : '0;
      out_user_r <= {full_now, empty_r, stat_r};
    end
  end

  assign dp_stat.out_stall = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_pop           = out_pop_r;
  assign out_user          = out_user_r;

  a_step_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl_cmd.step && ctrl_cmd.load))
    else $error("step and load in the same cycle");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_r == '0 && rear_r == '0))
    else $error("empty deque with nonzero indices");

  a_load_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten while stalled");

endmodule

// ----- rtl/circular_deque_unit.sv -----
// top level of the circular deque
//
//  channel | ports                 | content
//  in      | in_tvalid/tready      | tuser: command; tdata: push_value
//  out     | out_tvalid/tready     | tdata: pop_value; tuser: status, now_empty, now_full
//
// each transfer, in the idle state, updates the indices and does at most one
// memory access; the response state then loads the registered read data into
// the result register. a stalled result holds the controller until it can load.
// synchronous active-low reset empties the deque; entry memory is not cleared.
module circular_deque_unit #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cdq_pkg::PUSH_W-1:0]     in_tdata,   // [31:0] push_value
  input  logic [cdq_pkg::CMD_W-1:0]      in_tuser,   // [1:0] command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cdq_pkg::POP_W-1:0]      out_tdata,  // [31:0] pop_value
  output logic [cdq_pkg::OUT_USER_W-1:0] out_tuser   // [1:0] status, [2] now_empty, [3] now_full
);
  import cdq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .dp_stat  (dp_stat),
    .in_ready (in_tready),
    .ctrl_cmd (ctrl_cmd)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_cmd  (ctrl_cmd),
    .dp_stat   (dp_stat),
    .in_cmd    (in_tuser),
    .in_push   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pop   (out_tdata),
    .out_user  (out_tuser)
  );

endmodule
